### rtl/core/cbc_pkg.sv
// cbc_pkg: shared widths, register indexes, reset values and types for the
// red-blob centroid block. No dependencies.

package cbc_pkg;

	// field widths
	localparam int HUE_W      = 8;
	localparam int SAT_W      = 8;
	localparam int COORD_IN_W = 10;
	localparam int COUNT_W    = 21;
	localparam int SUM_W      = 31;
	localparam int COORD_W    = 11;

	// configuration port
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 21;

	localparam logic [CFG_INDEX_W-1:0] REG_HUE_LOW  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_HIGH = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAT      = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_CNT  = 8'd3;

	localparam logic [HUE_W-1:0]   HUE_LOW_RST  = 8'd3;
	localparam logic [HUE_W-1:0]   HUE_HIGH_RST = 8'd173;
	localparam logic [SAT_W-1:0]   SAT_RST      = 8'd170;
	localparam logic [COUNT_W-1:0] MIN_CNT_RST  = 21'd50;

	// saturation limits of the accumulators
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

	// frame geometry and coordinate clamp
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COORD_TOP  = (1 << COORD_IN_W) - 1;
	localparam int X_LIMIT    = (MAX_WIDTH - 1 > COORD_TOP) ? COORD_TOP : MAX_WIDTH - 1;
	localparam int Y_LIMIT    = (MAX_HEIGHT - 1 > COORD_TOP) ? COORD_TOP : MAX_HEIGHT - 1;

	// coordinate reported when no blob was found (-1)
	localparam logic signed [COORD_W-1:0] COORD_NONE = '1;

	// default depth of the frame job queue
	localparam int JOB_DEPTH_DEF = 2;

	typedef struct packed {
		logic [HUE_W-1:0] hue_low;
		logic [HUE_W-1:0] hue_high;
		logic [SAT_W-1:0] sat;
	} limits_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum_col;
		logic [SUM_W-1:0]   sum_row;
	} job_t;

endpackage

### rtl/core/cbc_pixel_if.sv
// cbc_pixel_if: pixel stream channel, valid/ready with HSV and position payload.
// Depends on cbc_pkg.

interface cbc_pixel_if import cbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [HUE_W-1:0]      hue;
	logic [SAT_W-1:0]      sat;
	logic [COORD_IN_W-1:0] col;
	logic [COORD_IN_W-1:0] row;
	logic                  frame_end;

	modport source(output valid, hue, sat, col, row, frame_end, input ready);
	modport sink(input valid, hue, sat, col, row, frame_end, output ready);
endinterface

### rtl/core/cbc_result_if.sv
// cbc_result_if: per-frame centroid result channel, valid/ready.
// Depends on cbc_pkg.

interface cbc_result_if import cbc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;

	modport source(output valid, found, center_x, center_y, input ready);
	modport sink(input valid, found, center_x, center_y, output ready);
endinterface

### rtl/core/cbc_cfg_if.sv
// cbc_cfg_if: configuration write channel, register index and write data.
// Depends on cbc_pkg.

interface cbc_cfg_if import cbc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/cbc_front.sv
// cbc_front: classifies pixels as red and accumulates count and position sums,
// handing one job per frame to the job queue. Depends on cbc_pkg, cbc_pixel_if.

module cbc_front import cbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cbc_pixel_if.sink         pixel,
	input  limits_t           limits,
	input  logic              job_full,
	output logic              job_push,
	output job_t              job
);

	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_col_q;
	logic [SUM_W-1:0]   sum_row_q;

	logic               accept;
	logic               red;
	logic [SUM_W:0]     col_add;
	logic [SUM_W:0]     row_add;
	logic [COUNT_W-1:0] count_nxt;
	logic [SUM_W-1:0]   sum_col_nxt;
	logic [SUM_W-1:0]   sum_row_nxt;

	// stall only when the job queue cannot take a frame end
	assign pixel.ready = !job_full;
	assign accept      = pixel.valid && pixel.ready;

	// red test: hue outside the band and saturation above the limit
	assign red = (pixel.hue < limits.hue_low || pixel.hue > limits.hue_high)
		&& pixel.sat > limits.sat;

	// saturating accumulate
	assign col_add = {1'b0, sum_col_q} + (SUM_W+1)'(pixel.col);
	assign row_add = {1'b0, sum_row_q} + (SUM_W+1)'(pixel.row);

	always_comb begin
		count_nxt   = count_q;
		sum_col_nxt = sum_col_q;
		sum_row_nxt = sum_row_q;
		if (red) begin
			if (count_q != COUNT_MAX) begin
				count_nxt = count_q + COUNT_W'(1);
			end
			sum_col_nxt = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
			sum_row_nxt = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
		end
	end

	// frame end pushes the totals including the last pixel
	assign job_push    = accept && pixel.frame_end;
	assign job.count   = count_nxt;
	assign job.sum_col = sum_col_nxt;
	assign job.sum_row = sum_row_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_col_q <= '0;
			sum_row_q <= '0;
		end else if (accept) begin
			if (pixel.frame_end) begin
				count_q   <= '0;
				sum_col_q <= '0;
				sum_row_q <= '0;
			end else begin
				count_q   <= count_nxt;
				sum_col_q <= sum_col_nxt;
				sum_row_q <= sum_row_nxt;
			end
		end
	end

endmodule

### rtl/core/cbc_job_fifo.sv
// cbc_job_fifo: short queue of per-frame jobs between front and back.
// Depends on cbc_pkg.

module cbc_job_fifo import cbc_pkg::*; #(
	parameter int DEPTH = JOB_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == CNT_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/cbc_back.sv
// cbc_back: takes frame jobs, divides both sums by the count one quotient bit
// per cycle, clamps and registers the result. Depends on cbc_pkg, cbc_result_if.

module cbc_back import cbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] min_count,
	input  logic               job_empty,
	input  job_t               job,
	output logic               job_pop,
	cbc_result_if.source       result
);

	localparam int STEP_W = $clog2(SUM_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic                found_q;
	logic [COUNT_W-1:0]  divisor_q;
	logic [SUM_W-1:0]    quo_col_q;
	logic [SUM_W-1:0]    quo_row_q;
	logic [COUNT_W-1:0]  rem_col_q;
	logic [COUNT_W-1:0]  rem_row_q;

	logic                out_valid_q;
	logic                out_found_q;
	logic [COORD_W-1:0]  out_x_q;
	logic [COORD_W-1:0]  out_y_q;

	logic                job_found;
	logic                out_free;
	logic [COUNT_W:0]    trial_col;
	logic [COUNT_W:0]    trial_row;
	logic                ge_col;
	logic                ge_row;
	logic [COUNT_W:0]    diff_col;
	logic [COUNT_W:0]    diff_row;
	logic [COORD_W-1:0]  clamp_x;
	logic [COORD_W-1:0]  clamp_y;

	// a frame is found only with a nonzero count that reaches min_count
	assign job_found = (job.count != '0) && (job.count >= min_count);
	assign job_pop   = (state_q == ST_IDLE) && !job_empty;
	assign out_free  = !out_valid_q || result.ready;

	// restoring division step for both coordinates
	assign trial_col = {rem_col_q, quo_col_q[SUM_W-1]};
	assign trial_row = {rem_row_q, quo_row_q[SUM_W-1]};
	assign ge_col    = trial_col >= {1'b0, divisor_q};
	assign ge_row    = trial_row >= {1'b0, divisor_q};
	assign diff_col  = trial_col - {1'b0, divisor_q};
	assign diff_row  = trial_row - {1'b0, divisor_q};

	// clamp quotients to the frame limits
	assign clamp_x = (quo_col_q > SUM_W'(X_LIMIT)) ? COORD_W'(X_LIMIT)
		: {1'b0, quo_col_q[COORD_IN_W-1:0]};
	assign clamp_y = (quo_row_q > SUM_W'(Y_LIMIT)) ? COORD_W'(Y_LIMIT)
		: {1'b0, quo_row_q[COORD_IN_W-1:0]};

	// sequencer and divider datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						step_q  <= '0;
						state_q <= job_found ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			found_q   <= job_found;
			divisor_q <= job.count;
			quo_col_q <= job.sum_col;
			quo_row_q <= job.sum_row;
			rem_col_q <= '0;
			rem_row_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_col_q <= {quo_col_q[SUM_W-2:0], ge_col};
			quo_row_q <= {quo_row_q[SUM_W-2:0], ge_row};
			rem_col_q <= ge_col ? diff_col[COUNT_W-1:0] : trial_col[COUNT_W-1:0];
			rem_row_q <= ge_row ? diff_row[COUNT_W-1:0] : trial_row[COUNT_W-1:0];
		end
	end

	// output register, holds until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_found_q <= found_q;
			out_x_q     <= found_q ? clamp_x : COORD_NONE;
			out_y_q     <= found_q ? clamp_y : COORD_NONE;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.found    = out_found_q;
	assign result.center_x = out_x_q;
	assign result.center_y = out_y_q;

endmodule

### rtl/core/color_blob_centroid_top.sv
// color_blob_centroid_top: red-blob centroid over an HSV pixel stream.
// Depends on cbc_pkg, the channel interfaces, cbc_front, cbc_job_fifo, cbc_back.

// Pixels are taken one per clock. Each pixel is tested against the hue band
// and saturation limit and folded into saturating count and position sums;
// the pixel marked frame_end closes the frame and its totals go into a job
// queue of JOB_DEPTH entries. The back end divides both sums by the count
// with a restoring divider that makes one quotient bit per cycle; a not-found
// frame skips the divide. One result per frame appears on the result channel.
// The pixel channel drops ready only while the job queue is full, which
// happens when frame ends arrive faster than one per divide or while the
// result channel holds off a waiting result.
module color_blob_centroid_top import cbc_pkg::*; #(
	parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cbc_pixel_if.sink     pixel,
	cbc_result_if.source  result,
	cbc_cfg_if.sink       cfg
);

	logic [HUE_W-1:0]   hue_low_q;
	logic [HUE_W-1:0]   hue_high_q;
	logic [SAT_W-1:0]   sat_q;
	logic [COUNT_W-1:0] min_count_q;

	limits_t limits;
	job_t    push_job;
	job_t    pop_job;
	logic    job_push;
	logic    job_pop;
	logic    job_full;
	logic    job_empty;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q   <= HUE_LOW_RST;
			hue_high_q  <= HUE_HIGH_RST;
			sat_q       <= SAT_RST;
			min_count_q <= MIN_CNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HUE_LOW:  hue_low_q   <= cfg.data[HUE_W-1:0];
				REG_HUE_HIGH: hue_high_q  <= cfg.data[HUE_W-1:0];
				REG_SAT:      sat_q       <= cfg.data[SAT_W-1:0];
				REG_MIN_CNT:  min_count_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign limits.hue_low  = hue_low_q;
	assign limits.hue_high = hue_high_q;
	assign limits.sat      = sat_q;

	// pixel classification and accumulation
	cbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel),
		.limits   (limits),
		.job_full (job_full),
		.job_push (job_push),
		.job      (push_job)
	);

	// per-frame job queue
	cbc_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.pop_job  (pop_job),
		.full     (job_full),
		.empty    (job_empty)
	);

	// divide, clamp and report
	cbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_count (min_count_q),
		.job_empty (job_empty),
		.job       (pop_job),
		.job_pop   (job_pop),
		.result    (result)
	);

	// a found centroid lies inside the clamped frame
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.found |->
			!result.center_x[COORD_W-1] && !result.center_y[COORD_W-1]
			&& result.center_x[COORD_IN_W-1:0] <= COORD_IN_W'(X_LIMIT)
			&& result.center_y[COORD_IN_W-1:0] <= COORD_IN_W'(Y_LIMIT))
		else $error("found centroid outside frame limits");

	// not found reports -1 on both coordinates
	a_not_found_none: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |->
			result.center_x == COORD_NONE && result.center_y == COORD_NONE)
		else $error("not-found result without -1 coordinates");

	// a frame end is never accepted while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("frame job pushed into a full queue");

endmodule
